FILE: src/quic_coalesced_packet_splitter_assert.svh
// Assertion helpers for the packet splitter checker.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef QUIC_COALESCED_PACKET_SPLITTER_ASSERT_SVH
`define QUIC_COALESCED_PACKET_SPLITTER_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define QCPS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define QCPS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/qcps_pkg.sv
package qcps_pkg;

  // Field widths
  localparam int BYTE_W      = 8;
  localparam int PKT_START_W = 16;
  localparam int PKT_LEN_W   = 17;
  localparam int KIND_W      = 3;
  localparam int STATUS_W    = 2;
  localparam int SKIP_W      = 62;
  localparam int VLEFT_W     = 3;

  // Header bits of the first packet byte
  localparam int LONG_HDR_BIT  = 7;
  localparam int FIXED_BIT     = 6;
  localparam int TYPE_HI_BIT   = 5;
  localparam int TYPE_LO_BIT   = 4;

  // Number of version bytes after a long header's first byte
  localparam logic [SKIP_W-1:0] VERSION_BYTES = SKIP_W'(4);

  // Reset value of the connection ID length limit
  localparam logic [BYTE_W-1:0] MAX_CID_RESET = 8'd20;

  // Packet kinds
  localparam logic [KIND_W-1:0] KIND_INITIAL   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_ZERO_RTT  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_HANDSHAKE = 3'd2;
  localparam logic [KIND_W-1:0] KIND_RETRY     = 3'd3;
  localparam logic [KIND_W-1:0] KIND_SHORT     = 3'd4;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FIXED_BIT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_CID_LONG  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_TRUNCATED = 2'd3;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              last_byte;
  } qcps_in_t;

  typedef struct packed {
    logic [PKT_START_W-1:0] pkt_start;
    logic [PKT_LEN_W-1:0]   pkt_len;
    logic [KIND_W-1:0]      pkt_kind;
    logic [BYTE_W-1:0]      dest_id_len;
    logic [BYTE_W-1:0]      src_id_len;
    logic [STATUS_W-1:0]    status;
    logic                   closes_datagram;
  } qcps_out_t;

endpackage

FILE: src/qcps_parse.sv
module qcps_parse #(
  parameter int MAX_DATAGRAM_BYTES = 65536
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     step,
  input  qcps_pkg::qcps_in_t       item,
  input  logic [7:0]               max_cid_len,
  output logic                     res_valid,
  output qcps_pkg::qcps_out_t      res
);
  import qcps_pkg::*;

  localparam int OFS_W = $clog2(MAX_DATAGRAM_BYTES + 1);
  localparam int BEG_W = $clog2(MAX_DATAGRAM_BYTES);

  typedef enum logic [10:0] {
    PH_START      = 11'b000_0000_0001,
    PH_VERSION    = 11'b000_0000_0010,
    PH_DCID_LEN   = 11'b000_0000_0100,
    PH_DCID       = 11'b000_0000_1000,
    PH_SCID_LEN   = 11'b000_0001_0000,
    PH_SCID       = 11'b000_0010_0000,
    PH_TOKEN_SIZE = 11'b000_0100_0000,
    PH_TOKEN      = 11'b000_1000_0000,
    PH_LENGTH     = 11'b001_0000_0000,
    PH_PAYLOAD    = 11'b010_0000_0000,
    PH_TO_END     = 11'b100_0000_0000
  } phase_t;

  phase_t              phase_r, phase_nxt, after_sid;
  logic [OFS_W-1:0]    ofs_r, ofs_nxt;
  logic [BEG_W-1:0]    beg_r, beg_nxt;
  logic [SKIP_W-1:0]   skip_r, skip_nxt, skip_dec;
  logic [SKIP_W-1:0]   vval_r, vval_nxt, vval_new;
  logic [VLEFT_W-1:0]  vleft_r, vleft_nxt, vleft_new;
  logic [KIND_W-1:0]   kind_r, kind_nxt;
  logic [BYTE_W-1:0]   dlen_r, dlen_nxt;
  logic [BYTE_W-1:0]   slen_r, slen_nxt;
  logic                drop_r, drop_nxt;
  logic                skip_done, vdone;
  logic                err, ok, last;
  logic [STATUS_W-1:0] err_code;
  logic [BYTE_W-1:0]   d;

  assign d    = item.data_byte;
  assign last = item.last_byte;

  // Skip counter: saturating decrement, done once it reaches zero
  assign skip_dec  = (skip_r != '0) ? skip_r - SKIP_W'(1) : '0;
  assign skip_done = (skip_dec == '0);

  // Varint: first byte sets the count of bytes still to come (0, 1, 3 or 7)
  always_comb begin
    if (vleft_r == '0) begin
      vleft_new = {d[7] & d[6], d[7], d[7] | d[6]};
      vval_new  = {{(SKIP_W-6){1'b0}}, d[5:0]};
    end else begin
      vleft_new = vleft_r - VLEFT_W'(1);
      vval_new  = {vval_r[SKIP_W-9:0], d};
    end
  end
  assign vdone = (vleft_new == '0);

  // Phase that follows the source connection ID
  always_comb begin
    case (kind_r)
      KIND_INITIAL: after_sid = PH_TOKEN_SIZE;
      KIND_RETRY:   after_sid = PH_TO_END;
      default:      after_sid = PH_LENGTH;
    endcase
  end

  // Per-byte parse step
  always_comb begin
    phase_nxt = phase_r;
    ofs_nxt   = ofs_r;
    beg_nxt   = beg_r;
    skip_nxt  = skip_r;
    vval_nxt  = vval_r;
    vleft_nxt = vleft_r;
    kind_nxt  = kind_r;
    dlen_nxt  = dlen_r;
    slen_nxt  = slen_r;
    drop_nxt  = drop_r;
    err       = 1'b0;
    ok        = 1'b0;
    err_code  = ST_TRUNCATED;
    res_valid = 1'b0;
    res.pkt_start       = PKT_START_W'(beg_r);
    res.pkt_len         = '0;
    res.pkt_kind        = kind_r;
    res.dest_id_len     = dlen_r;
    res.src_id_len      = slen_r;
    res.status          = ST_TRUNCATED;
    res.closes_datagram = 1'b1;

    if (drop_r) begin
      // discard until the datagram's last byte
    end else if (ofs_r >= OFS_W'(MAX_DATAGRAM_BYTES)) begin
      // oversize datagram
      res_valid = 1'b1;
      drop_nxt  = 1'b1;
    end else begin
      ofs_nxt = ofs_r + OFS_W'(1);
      case (phase_r)
        PH_START: begin
          beg_nxt  = BEG_W'(ofs_r);
          dlen_nxt = '0;
          slen_nxt = '0;
          kind_nxt = d[LONG_HDR_BIT] ? {1'b0, d[TYPE_HI_BIT], d[TYPE_LO_BIT]} : KIND_SHORT;
          if (!d[FIXED_BIT]) begin
            err      = 1'b1;
            err_code = ST_FIXED_BIT;
          end else if (d[LONG_HDR_BIT]) begin
            skip_nxt  = VERSION_BYTES;
            phase_nxt = PH_VERSION;
          end else begin
            phase_nxt = PH_TO_END;
          end
        end
        PH_VERSION: begin
          skip_nxt = skip_dec;
          if (skip_done) phase_nxt = PH_DCID_LEN;
        end
        PH_DCID_LEN: begin
          dlen_nxt = d;
          if (!last && d > max_cid_len) begin
            err      = 1'b1;
            err_code = ST_CID_LONG;
          end else if (d == '0) begin
            phase_nxt = PH_SCID_LEN;
          end else begin
            skip_nxt  = SKIP_W'(d);
            phase_nxt = PH_DCID;
          end
        end
        PH_DCID: begin
          skip_nxt = skip_dec;
          if (skip_done) phase_nxt = PH_SCID_LEN;
        end
        PH_SCID_LEN: begin
          slen_nxt = d;
          if (d > max_cid_len) begin
            err      = 1'b1;
            err_code = ST_CID_LONG;
          end else if (d == '0) begin
            vleft_nxt = '0;
            phase_nxt = after_sid;
          end else begin
            skip_nxt  = SKIP_W'(d);
            phase_nxt = PH_SCID;
          end
        end
        PH_SCID: begin
          skip_nxt = skip_dec;
          if (skip_done) begin
            vleft_nxt = '0;
            phase_nxt = after_sid;
          end
        end
        PH_TOKEN_SIZE: begin
          vleft_nxt = vleft_new;
          vval_nxt  = vval_new;
          if (vdone) begin
            if (vval_new == '0) begin
              phase_nxt = PH_LENGTH;
            end else begin
              skip_nxt  = vval_new;
              phase_nxt = PH_TOKEN;
            end
          end
        end
        PH_TOKEN: begin
          skip_nxt = skip_dec;
          if (skip_done) begin
            vleft_nxt = '0;
            phase_nxt = PH_LENGTH;
          end
        end
        PH_LENGTH: begin
          vleft_nxt = vleft_new;
          vval_nxt  = vval_new;
          if (vdone) begin
            if (vval_new == '0) begin
              ok = 1'b1;
            end else begin
              skip_nxt  = vval_new;
              phase_nxt = PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          skip_nxt = skip_dec;
          if (skip_done) ok = 1'b1;
        end
        PH_TO_END: begin
          // runs to the end of the datagram
        end
        default: begin
          err = 1'b1;
        end
      endcase

      // datagram ends: short header or Retry completes, anything else is cut short
      if (!err && !ok && last) begin
        if (phase_nxt == PH_TO_END) ok  = 1'b1;
        else                        err = 1'b1;
      end

      res_valid           = ok | err;
      res.pkt_start       = PKT_START_W'(beg_nxt);
      res.pkt_kind        = kind_nxt;
      res.dest_id_len     = dlen_nxt;
      res.src_id_len      = slen_nxt;
      res.pkt_len         = PKT_LEN_W'(ofs_r) - PKT_LEN_W'(beg_nxt) + PKT_LEN_W'(1);
      res.status          = ST_OK;
      res.closes_datagram = last;
      if (err) begin
        res.pkt_len         = '0;
        res.status          = err_code;
        res.closes_datagram = 1'b1;
        drop_nxt            = 1'b1;
      end
      if (ok) phase_nxt = PH_START;
    end

    // last byte rearms for the next datagram
    if (last) begin
      phase_nxt = PH_START;
      ofs_nxt   = '0;
      beg_nxt   = '0;
      skip_nxt  = '0;
      vval_nxt  = '0;
      vleft_nxt = '0;
      kind_nxt  = '0;
      dlen_nxt  = '0;
      slen_nxt  = '0;
      drop_nxt  = 1'b0;
    end
  end

  // Parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_START;
      ofs_r   <= '0;
      beg_r   <= '0;
      skip_r  <= '0;
      vval_r  <= '0;
      vleft_r <= '0;
      kind_r  <= '0;
      dlen_r  <= '0;
      slen_r  <= '0;
      drop_r  <= 1'b0;
    end else if (step) begin
      phase_r <= phase_nxt;
      ofs_r   <= ofs_nxt;
      beg_r   <= beg_nxt;
      skip_r  <= skip_nxt;
      vval_r  <= vval_nxt;
      vleft_r <= vleft_nxt;
      kind_r  <= kind_nxt;
      dlen_r  <= dlen_nxt;
      slen_r  <= slen_nxt;
      drop_r  <= drop_nxt;
    end
  end

endmodule

FILE: src/quic_coalesced_packet_splitter.sv
// Path: each accepted byte passes through the input register and the parse step; the
//   result of the byte that ends the packet is then captured in the result register.
// Throughput: one datagram byte per cycle, limited by the single parse step
//   between the two registers; a stalled result register holds the input.
// Reset (rst_n low, synchronous): pipeline empty, parser waits for the first
//   byte of a datagram, max_cid_len returns to 20.
module quic_coalesced_packet_splitter #(
  parameter int MAX_DATAGRAM_BYTES = 65536
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  qcps_pkg::qcps_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output qcps_pkg::qcps_out_t out_data,
  input  logic                cfg_wr_en,
  input  logic [7:0]          cfg_wr_data
);
  import qcps_pkg::*;

  logic              s1_valid_r, s1_valid_nxt;
  qcps_in_t          s1_data_r;
  logic              out_valid_r, out_valid_nxt;
  qcps_out_t         out_data_r;
  logic [BYTE_W-1:0] max_cid_r;
  logic              advance, take, res_valid;
  qcps_out_t         res;

  // Handshake control
  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !advance;
  assign take     = in_valid && !in_stall;

  assign s1_valid_nxt  = take ? 1'b1 : (advance ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = (advance && res_valid) ? 1'b1
                       : ((out_valid_r && !out_stall) ? 1'b0 : out_valid_r);

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) s1_data_r <= in_data;
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_cid_r <= MAX_CID_RESET;
    end else if (cfg_wr_en) begin
      max_cid_r <= cfg_wr_data;
    end
  end

  // Parser
  qcps_parse #(
    .MAX_DATAGRAM_BYTES(MAX_DATAGRAM_BYTES)
  ) u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (advance),
    .item       (s1_data_r),
    .max_cid_len(max_cid_r),
    .res_valid  (res_valid),
    .res        (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) out_data_r <= res;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: src/qcps_checker.sv
module qcps_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                out_valid,
  input  logic                out_stall,
  input  qcps_pkg::qcps_out_t out_data
);
  import qcps_pkg::*;
  `include "quic_coalesced_packet_splitter_assert.svh"

  // stalled result holds
  `QCPS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")

  // errors carry zero length and close the datagram
  `QCPS_ASSERT_SAME(a_err_shape, out_valid && out_data.status != ST_OK, out_data.pkt_len == '0 && out_data.closes_datagram, "error result malformed")

  // a good packet is never empty
  `QCPS_ASSERT_SAME(a_ok_len, out_valid && out_data.status == ST_OK, out_data.pkt_len != '0, "ok result with zero length")

  // short headers carry no connection ID lengths
  `QCPS_ASSERT_SAME(a_short_cid, out_valid && out_data.pkt_kind == KIND_SHORT, out_data.dest_id_len == '0 && out_data.src_id_len == '0, "short header with CID length")

endmodule

bind quic_coalesced_packet_splitter qcps_checker u_qcps_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data (out_data)
);
